// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the machine state controller: state and
// opcode codes, command codes, counter width and the update control bundle.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int COUNT_WIDTH = 32;

	typedef enum logic [4:0] {
		ST_UNDEFINED    = 5'd0,
		ST_CLEARING     = 5'd1,
		ST_STOPPED      = 5'd2,
		ST_STARTING     = 5'd3,
		ST_IDLE         = 5'd4,
		ST_SUSPENDED    = 5'd5,
		ST_EXECUTE      = 5'd6,
		ST_STOPPING     = 5'd7,
		ST_ABORTING     = 5'd8,
		ST_ABORTED      = 5'd9,
		ST_HOLDING      = 5'd10,
		ST_HELD         = 5'd11,
		ST_UNHOLDING    = 5'd12,
		ST_SUSPENDING   = 5'd13,
		ST_UNSUSPENDING = 5'd14,
		ST_RESETTING    = 5'd15,
		ST_COMPLETING   = 5'd16,
		ST_COMPLETE     = 5'd17
	} state_t;

	typedef enum logic [2:0] {
		OP_COMMAND    = 3'd0,
		OP_STATE_DONE = 3'd1,
		OP_EXEC_DONE  = 3'd2,
		OP_COUNT      = 3'd3,
		OP_SET_MODE   = 3'd4,
		OP_SET_SPEED  = 3'd5,
		OP_INIT       = 3'd6,
		OP_TICK       = 3'd7
	} opcode_t;

	localparam logic [3:0] CMD_RESET     = 4'd1;
	localparam logic [3:0] CMD_START     = 4'd2;
	localparam logic [3:0] CMD_STOP      = 4'd3;
	localparam logic [3:0] CMD_HOLD      = 4'd4;
	localparam logic [3:0] CMD_UNHOLD    = 4'd5;
	localparam logic [3:0] CMD_SUSPEND   = 4'd6;
	localparam logic [3:0] CMD_UNSUSPEND = 4'd7;
	localparam logic [3:0] CMD_ABORT     = 4'd8;
	localparam logic [3:0] CMD_CLEAR     = 4'd9;

	localparam logic [7:0] MODE_PRODUCING = 8'd1;

	typedef struct packed {
		logic   accepted;
		state_t state_nx;
		logic   clr_state_time;
		logic   clr_run_time;
		logic   clr_counts;
		logic   tick;
		logic   count;
		logic   defective;
		logic   mode_load;
		logic   speed_load;
		logic   speed_clr;
	} upd_t;

endpackage

// ===== rtl/psc_if.sv =====
// ----------------------------------------------------------------------------
// psc_in_if / psc_out_if
// Valid/ready channels carrying one input item and one status result.
// ----------------------------------------------------------------------------
interface psc_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [3:0]         command;
	logic               defective_unit;
	logic [7:0]         mode_value;
	logic signed [31:0] speed_value;

	modport source (output valid, opcode, command, defective_unit, mode_value, speed_value,
		input ready);
	modport sink (input valid, opcode, command, defective_unit, mode_value, speed_value,
		output ready);
endinterface

interface psc_out_if;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [4:0]         current_state;
	logic [7:0]         current_mode;
	logic signed [31:0] actual_speed;
	logic [31:0]        state_elapsed;
	logic [31:0]        run_elapsed;
	logic [31:0]        processed_count;
	logic [31:0]        defective_count;

	modport source (output valid, accepted, current_state, current_mode, actual_speed,
		state_elapsed, run_elapsed, processed_count, defective_count, input ready);
	modport sink (input valid, accepted, current_state, current_mode, actual_speed,
		state_elapsed, run_elapsed, processed_count, defective_count, output ready);
endinterface

// ===== rtl/psc_fsm.sv =====
// ----------------------------------------------------------------------------
// psc_fsm
// Transition logic of the machine state model. Decodes one item against the
// present state and produces the next state and the update controls.
// ----------------------------------------------------------------------------
module psc_fsm import psc_pkg::*; (
	input  state_t     state,
	input  logic [2:0] opcode,
	input  logic [3:0] command,
	input  logic       defective_unit,
	output upd_t       upd
);

	state_t cmd_nx;
	state_t done_nx;
	logic   abort_branch;

	always_comb begin
		abort_branch = (state == ST_ABORTING) || (state == ST_ABORTED);
		cmd_nx = state;
		if (command == CMD_ABORT && !abort_branch) begin
			cmd_nx = ST_ABORTING;
		end else if (command == CMD_STOP && !abort_branch && state != ST_STOPPING &&
				state != ST_STOPPED && state != ST_CLEARING) begin
			cmd_nx = ST_STOPPING;
		end else begin
			case (state)
				ST_STOPPED, ST_COMPLETE: begin
					if (command == CMD_RESET) cmd_nx = ST_RESETTING;
				end
				ST_IDLE: begin
					if (command == CMD_START) cmd_nx = ST_STARTING;
				end
				ST_EXECUTE: begin
					if (command == CMD_HOLD) cmd_nx = ST_HOLDING;
					else if (command == CMD_SUSPEND) cmd_nx = ST_SUSPENDING;
				end
				ST_HELD: begin
					if (command == CMD_UNHOLD) cmd_nx = ST_UNHOLDING;
				end
				ST_SUSPENDED: begin
					if (command == CMD_UNSUSPEND) cmd_nx = ST_UNSUSPENDING;
				end
				ST_ABORTED: begin
					if (command == CMD_CLEAR) cmd_nx = ST_CLEARING;
				end
				default: cmd_nx = state;
			endcase
		end
	end

	always_comb begin
		case (state)
			ST_RESETTING:    done_nx = ST_IDLE;
			ST_STARTING:     done_nx = ST_EXECUTE;
			ST_HOLDING:      done_nx = ST_HELD;
			ST_UNHOLDING:    done_nx = ST_EXECUTE;
			ST_SUSPENDING:   done_nx = ST_SUSPENDED;
			ST_UNSUSPENDING: done_nx = ST_EXECUTE;
			ST_COMPLETING:   done_nx = ST_COMPLETE;
			ST_STOPPING:     done_nx = ST_STOPPED;
			ST_ABORTING:     done_nx = ST_ABORTED;
			ST_CLEARING:     done_nx = ST_STOPPED;
			default:         done_nx = state;
		endcase
	end

	always_comb begin
		upd = '0;
		upd.state_nx  = state;
		upd.defective = defective_unit;
		unique case (opcode_t'(opcode))
			OP_COMMAND: begin
				if (cmd_nx != state) begin
					upd.state_nx     = cmd_nx;
					upd.accepted     = 1'b1;
					upd.clr_run_time = (command == CMD_RESET);
				end
			end
			OP_STATE_DONE: upd.state_nx = done_nx;
			OP_EXEC_DONE: begin
				if (state == ST_EXECUTE) begin
					upd.state_nx = ST_COMPLETING;
					upd.accepted = 1'b1;
				end
			end
			OP_COUNT: upd.count = (state == ST_EXECUTE);
			OP_SET_MODE: begin
				if (state == ST_STOPPED || state == ST_IDLE || state == ST_ABORTED) begin
					upd.mode_load = 1'b1;
					upd.accepted  = 1'b1;
				end
			end
			OP_SET_SPEED: upd.speed_load = 1'b1;
			OP_INIT: begin
				upd.state_nx       = ST_STOPPED;
				upd.mode_load      = 1'b1;
				upd.speed_clr      = 1'b1;
				upd.clr_counts     = 1'b1;
				upd.clr_run_time   = 1'b1;
				upd.clr_state_time = 1'b1;
			end
			OP_TICK: upd.tick = 1'b1;
			default: upd.state_nx = state;
		endcase
		if (upd.state_nx != state) upd.clr_state_time = 1'b1;
	end

endmodule

// ===== rtl/psc_ctr.sv =====
// ----------------------------------------------------------------------------
// psc_ctr
// Unit counters and millisecond timers. Holds the running values and gives
// their values after the current update.
// ----------------------------------------------------------------------------
module psc_ctr import psc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  upd_t        upd,
	output logic [31:0] state_time_nx,
	output logic [31:0] run_time_nx,
	output logic [31:0] processed_nx,
	output logic [31:0] defective_nx
);

	logic [COUNT_WIDTH-1:0] processed_q;
	logic [COUNT_WIDTH-1:0] defective_q;
	logic [COUNT_WIDTH-1:0] processed_d;
	logic [COUNT_WIDTH-1:0] defective_d;
	logic [31:0]            state_time_q;
	logic [31:0]            run_time_q;

	always_comb begin
		processed_d   = processed_q;
		defective_d   = defective_q;
		state_time_nx = state_time_q;
		run_time_nx   = run_time_q;
		if (upd.clr_counts) begin
			processed_d = '0;
			defective_d = '0;
		end else if (upd.count) begin
			processed_d = processed_q + COUNT_WIDTH'(1);
			if (upd.defective) defective_d = defective_q + COUNT_WIDTH'(1);
		end
		if (upd.tick) begin
			state_time_nx = state_time_q + 32'd1;
			run_time_nx   = run_time_q + 32'd1;
		end
		if (upd.clr_state_time) state_time_nx = '0;
		if (upd.clr_run_time) run_time_nx = '0;
	end

	assign processed_nx = 32'(processed_d);
	assign defective_nx = 32'(defective_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			processed_q  <= '0;
			defective_q  <= '0;
			state_time_q <= '0;
			run_time_q   <= '0;
		end else if (en) begin
			processed_q  <= processed_d;
			defective_q  <= defective_d;
			state_time_q <= state_time_nx;
			run_time_q   <= run_time_nx;
		end
	end

endmodule

// ===== rtl/packml_state_controller_unit.sv =====
// ----------------------------------------------------------------------------
// packml_state_controller_unit
// Machine state controller with mode, speed, unit counters and timers.
// ----------------------------------------------------------------------------
// One item is taken every clock while the result side is not stalled, and
// each returns one status result. An accepted item is held in the input
// register, where it is applied to the state, and its status is loaded into
// the result register when the result side can advance. A result that waits
// on the output side holds the input register, and the input stalls only
// when both registers are full. The rate is set by the single update of the
// state, counter and timer registers from the input register.
module packml_state_controller_unit import psc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	psc_in_if.sink    item,
	psc_out_if.source result
);

	logic               valid_s1;
	logic [2:0]         opcode_s1;
	logic [3:0]         command_s1;
	logic               defective_s1;
	logic [7:0]         mode_s1;
	logic signed [31:0] speed_s1;

	state_t             state_q;
	logic [7:0]         mode_q;
	logic signed [31:0] speed_q;
	logic [7:0]         mode_nx;
	logic signed [31:0] speed_nx;

	logic               out_valid_q;
	logic               advance;
	logic               fire;
	upd_t               upd;
	logic [31:0]        state_time_nx;
	logic [31:0]        run_time_nx;
	logic [31:0]        processed_nx;
	logic [31:0]        defective_nx;

	assign advance    = !out_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1    <= item.opcode;
			command_s1   <= item.command;
			defective_s1 <= item.defective_unit;
			mode_s1      <= item.mode_value;
			speed_s1     <= item.speed_value;
		end
	end

	psc_fsm u_fsm (
		.state          (state_q),
		.opcode         (opcode_s1),
		.command        (command_s1),
		.defective_unit (defective_s1),
		.upd            (upd)
	);

	psc_ctr u_ctr (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (fire),
		.upd           (upd),
		.state_time_nx (state_time_nx),
		.run_time_nx   (run_time_nx),
		.processed_nx  (processed_nx),
		.defective_nx  (defective_nx)
	);

	always_comb begin
		mode_nx  = upd.mode_load ? mode_s1 : mode_q;
		speed_nx = upd.speed_clr ? 32'sd0 : (upd.speed_load ? speed_s1 : speed_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_STOPPED;
			mode_q      <= MODE_PRODUCING;
			speed_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= upd.state_nx;
				mode_q  <= mode_nx;
				speed_q <= speed_nx;
			end
			if (advance) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result.accepted        <= upd.accepted;
			result.current_state   <= upd.state_nx;
			result.current_mode    <= mode_nx;
			result.actual_speed    <= (upd.state_nx == ST_EXECUTE) ? speed_nx : 32'sd0;
			result.state_elapsed   <= state_time_nx;
			result.run_elapsed     <= run_time_nx;
			result.processed_count <= processed_nx;
			result.defective_count <= defective_nx;
		end
	end

	assign result.valid = out_valid_q;

endmodule
